// ===== hdl/ssd_pkg.sv =====
`timescale 1ns / 1ps

package ssd_pkg;

	localparam int DATA_W = 32;
	localparam int ADDR_W = 4;
	localparam int FRAME_BYTES = 8;

	localparam logic [1:0] OP_COMMAND = 2'd0;
	localparam logic [1:0] OP_MODE    = 2'd1;
	localparam logic [1:0] OP_TICK    = 2'd2;
	localparam logic [1:0] OP_SEND    = 2'd3;

	localparam logic [1:0] REG_HALF_BASE = 2'd0;
	localparam logic [1:0] REG_MAX_SPEED = 2'd1;
	localparam logic [1:0] REG_WATCHDOG  = 2'd2;

	localparam logic [15:0] HALF_BASE_RST = 16'd350;
	localparam logic [15:0] MAX_SPEED_RST = 16'd2780;
	localparam logic [15:0] WATCHDOG_RST  = 16'd300;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] FRAME_SOF = 8'hAA;
	localparam logic [7:0] FRAME_CR  = 8'h0D;
	localparam logic [7:0] FRAME_LF  = 8'h0A;

	localparam logic [7:0] FLAG_LEFT_REV  = 8'h01;
	localparam logic [7:0] FLAG_RIGHT_REV = 8'h02;
	localparam logic [7:0] FLAG_IGNITION  = 8'h04;
	localparam logic [7:0] FLAGS_BRAKE    = 8'h4C;

	localparam logic [6:0] PCT_MAX = 7'd100;

	typedef struct packed {
		logic [15:0] half_base;
		logic [15:0] max_speed;
		logic [15:0] watchdog;
	} cfg_t;

	typedef struct packed {
		logic [6:0] left_power;
		logic [6:0] right_power;
		logic       left_rev;
		logic       right_rev;
	} mix_res_t;

endpackage

// ===== hdl/ssd_if.sv =====
`timescale 1ns / 1ps

interface ssd_in_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  operation;
	logic signed [15:0] linear_mm_s;
	logic signed [15:0] angular_mrad_s;
	logic               drive_req;

	modport source (output valid, output operation, output linear_mm_s,
		output angular_mrad_s, output drive_req, input ready);
	modport sink (input valid, input operation, input linear_mm_s,
		input angular_mrad_s, input drive_req, output ready);
endinterface

interface ssd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       last_byte;

	modport source (output valid, output tx_byte, output last_byte, input ready);
	modport sink (input valid, input tx_byte, input last_byte, output ready);
endinterface

// ===== hdl/skid_steer_drive_bridge.sv =====
// A mode switch or tick is handled directly in idle; a velocity command runs the
// bit-serial multiply, the side step and the bit-serial percent divide in turn.
// A send: bit-serial CRC, then 8 frame words, one per cycle unless out_ch stalls.
// One item is processed at a time; the last frame word may wait while the next item runs.
// Reset: arst_n is asynchronous, active low; it restores register defaults, pause
// mode, zero percents, zero flags and zero silence count.
`timescale 1ns / 1ps

module skid_steer_drive_bridge import ssd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	ssd_in_if.sink            in_ch,
	ssd_out_if.source         out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MIX  = 2'd1;
	localparam logic [1:0] ST_CRC  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;
	localparam logic [2:0] LAST_IDX = 3'(FRAME_BYTES - 1);

	cfg_t        cfg;
	mix_res_t    mix_res;
	logic        mix_done;
	logic        crc_busy;
	logic        crc_done;
	logic [15:0] crc_val;

	logic [1:0]  state_q;
	logic        drive_q;
	logic [6:0]  left_q, right_q;
	logic [7:0]  flags_q;
	logic [15:0] sil_q;
	logic [63:0] frame_q;
	logic [2:0]  ecnt_q;
	logic        out_valid_q;
	logic [7:0]  tx_q;
	logic        last_q;

	logic        in_fire;
	logic        out_free;
	logic        emit_fire;
	logic [15:0] sil_inc;

	assign in_ch.ready      = (state_q == ST_IDLE);
	assign in_fire          = in_ch.valid && in_ch.ready;
	assign out_free         = !out_valid_q || out_ch.ready;
	assign emit_fire        = (state_q == ST_EMIT) && out_free;
	assign sil_inc          = (sil_q == 16'hFFFF) ? sil_q : sil_q + 16'd1;
	assign out_ch.valid     = out_valid_q;
	assign out_ch.tx_byte   = tx_q;
	assign out_ch.last_byte = last_q;

	ssd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ssd_mixer u_mixer (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_fire && in_ch.operation == OP_COMMAND),
		.lin       (in_ch.linear_mm_s),
		.ang       (in_ch.angular_mrad_s),
		.half_base (cfg.half_base),
		.max_speed (cfg.max_speed),
		.done      (mix_done),
		.res       (mix_res)
	);

	ssd_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_fire && in_ch.operation == OP_SEND),
		.data   ({flags_q, 1'b0, right_q, 1'b0, left_q, FRAME_SOF}),
		.busy   (crc_busy),
		.done   (crc_done),
		.crc    (crc_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			drive_q     <= 1'b0;
			left_q      <= '0;
			right_q     <= '0;
			flags_q     <= '0;
			sil_q       <= '0;
			ecnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit_fire || (out_valid_q && !out_ch.ready);
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (in_ch.operation)
							OP_COMMAND: begin
								sil_q   <= '0;
								state_q <= ST_MIX;
							end
							OP_MODE: begin
								if (in_ch.drive_req && !drive_q) begin
									drive_q <= 1'b1;
								end else if (!in_ch.drive_req && drive_q) begin
									drive_q <= 1'b0;
									left_q  <= '0;
									right_q <= '0;
									flags_q <= FLAGS_BRAKE;
								end
							end
							OP_TICK: begin
								sil_q <= sil_inc;
								if (sil_inc > cfg.watchdog && drive_q) begin
									drive_q <= 1'b0;
									left_q  <= '0;
									right_q <= '0;
									flags_q <= FLAGS_BRAKE;
								end
							end
							OP_SEND: state_q <= ST_CRC;
							default: ;
						endcase
					end
				end
				ST_MIX: begin
					if (mix_done) begin
						state_q <= ST_IDLE;
						if (drive_q) begin
							left_q  <= mix_res.left_power;
							right_q <= mix_res.right_power;
							flags_q <= FLAG_IGNITION
								| (mix_res.left_rev ? FLAG_LEFT_REV : 8'd0)
								| (mix_res.right_rev ? FLAG_RIGHT_REV : 8'd0);
						end
					end
				end
				ST_CRC: begin
					if (crc_done) begin
						state_q <= ST_EMIT;
						ecnt_q  <= '0;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						ecnt_q <= ecnt_q + 3'd1;
						if (ecnt_q == LAST_IDX) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CRC && crc_done) begin
			frame_q <= {FRAME_LF, FRAME_CR, crc_val[7:0], crc_val[15:8],
				flags_q, 1'b0, right_q, 1'b0, left_q, FRAME_SOF};
		end else if (emit_fire) begin
			frame_q <= frame_q >> 8;
		end
		if (emit_fire) begin
			tx_q   <= frame_q[7:0];
			last_q <= (ecnt_q == LAST_IDX);
		end
	end

`ifndef NO_ASSERTIONS
	a_mix_done_in_mix: assert property (@(posedge clk) disable iff (!arst_n)
		mix_done |-> state_q == ST_MIX)
		else $error("mixer finished outside command processing");

	a_crc_only_in_send: assert property (@(posedge clk) disable iff (!arst_n)
		crc_busy |-> state_q == ST_CRC)
		else $error("crc running outside send processing");

	a_pause_braked: assert property (@(posedge clk) disable iff (!arst_n)
		!drive_q |-> left_q == 7'd0 && right_q == 7'd0
			&& (flags_q == 8'd0 || flags_q == FLAGS_BRAKE))
		else $error("pause mode with live drive outputs");

	a_last_word_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire && ecnt_q == LAST_IDX |=> state_q == ST_IDLE && out_ch.valid
			&& out_ch.last_byte)
		else $error("final frame word not flagged");
`endif

endmodule

// ===== hdl/ssd_regs.sv =====
`timescale 1ns / 1ps

module ssd_regs import ssd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic [1:0] idx;
	logic       wr_en;

	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_base <= HALF_BASE_RST;
			cfg_q.max_speed <= MAX_SPEED_RST;
			cfg_q.watchdog  <= WATCHDOG_RST;
		end else if (wr_en) begin
			case (idx)
				REG_HALF_BASE: cfg_q.half_base <= pwdata[15:0];
				REG_MAX_SPEED: cfg_q.max_speed <= pwdata[15:0];
				REG_WATCHDOG:  cfg_q.watchdog  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_HALF_BASE: prdata = {16'd0, cfg_q.half_base};
			REG_MAX_SPEED: prdata = {16'd0, cfg_q.max_speed};
			REG_WATCHDOG:  prdata = {16'd0, cfg_q.watchdog};
			default:       prdata = '0;
		endcase
	end

endmodule

// ===== hdl/ssd_mixer.sv =====
`timescale 1ns / 1ps

module ssd_mixer import ssd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] lin,
	input  logic signed [15:0] ang,
	input  logic        [15:0] half_base,
	input  logic        [15:0] max_speed,
	output logic               done,
	output mix_res_t           res
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MUL  = 2'd1;
	localparam logic [1:0] PH_SIDE = 2'd2;
	localparam logic [1:0] PH_DIV  = 2'd3;

	logic        [1:0]  phase_q;
	logic        [3:0]  cnt_q;
	logic signed [31:0] mcand_q;
	logic        [15:0] mplier_q;
	logic signed [31:0] acc_q;
	logic signed [25:0] link_q;
	logic        [26:0] dsh_q;
	logic        [31:0] reml_q, remr_q;
	logic        [7:0]  ql_q, qr_q;
	logic               revl_q, revr_q;
	logic               done_q;

	logic signed [25:0] lin_ext, lin_k;
	logic        [15:0] max_eff;
	logic        [19:0] divisor;
	logic signed [32:0] link_ext, acc_ext, vl, vr, negl, negr;
	logic        [31:0] dsh_ext, subl, subr;
	logic               gel, ger;

	assign lin_ext  = {{10{lin[15]}}, lin};
	assign lin_k    = (lin_ext <<< 10) - (lin_ext <<< 4) - (lin_ext <<< 3);
	assign max_eff  = (max_speed == 16'd0) ? 16'd1 : max_speed;
	assign divisor  = ({4'd0, max_eff} << 3) + ({4'd0, max_eff} << 1);

	assign link_ext = {{7{link_q[25]}}, link_q};
	assign acc_ext  = {acc_q[31], acc_q};
	assign vl       = link_ext - acc_ext;
	assign vr       = link_ext + acc_ext;
	assign negl     = -vl;
	assign negr     = -vr;

	assign dsh_ext  = {5'd0, dsh_q};
	assign gel      = reml_q >= dsh_ext;
	assign ger      = remr_q >= dsh_ext;
	assign subl     = reml_q - dsh_ext;
	assign subr     = remr_q - dsh_ext;

	function automatic logic [6:0] clamp_pct(input logic [7:0] q);
		clamp_pct = (q[7] || q[6:0] > PCT_MAX) ? PCT_MAX : q[6:0];
	endfunction

	assign done            = done_q;
	assign res.left_power  = clamp_pct(ql_q);
	assign res.right_power = clamp_pct(qr_q);
	assign res.left_rev    = revl_q;
	assign res.right_rev   = revr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (phase_q == PH_DIV) && (cnt_q == 4'd7);
			case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_MUL;
						cnt_q   <= '0;
					end
				end
				PH_MUL: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						phase_q <= PH_SIDE;
					end
				end
				PH_SIDE: begin
					phase_q <= PH_DIV;
					cnt_q   <= '0;
				end
				PH_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd7) begin
						phase_q <= PH_IDLE;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (start) begin
					mcand_q  <= {{16{ang[15]}}, ang};
					mplier_q <= half_base;
					acc_q    <= '0;
					link_q   <= lin_k;
					dsh_q    <= {divisor, 7'd0};
				end
			end
			PH_MUL: begin
				if (mplier_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q  <= mcand_q <<< 1;
				mplier_q <= mplier_q >> 1;
			end
			PH_SIDE: begin
				reml_q <= vl[32] ? negl[31:0] : vl[31:0];
				remr_q <= vr[32] ? negr[31:0] : vr[31:0];
				revl_q <= vl[32];
				revr_q <= vr[32];
				ql_q   <= '0;
				qr_q   <= '0;
			end
			PH_DIV: begin
				if (gel) begin
					reml_q <= subl;
				end
				if (ger) begin
					remr_q <= subr;
				end
				ql_q  <= {ql_q[6:0], gel};
				qr_q  <= {qr_q[6:0], ger};
				dsh_q <= dsh_q >> 1;
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/ssd_crc.sv =====
`timescale 1ns / 1ps

module ssd_crc import ssd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] data,
	output logic        busy,
	output logic        done,
	output logic [15:0] crc
);

	logic [31:0] sh_q;
	logic [15:0] crc_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic        fb;

	assign fb   = crc_q[0] ^ sh_q[0];
	assign busy = busy_q;
	assign done = done_q;
	assign crc  = crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd31);
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			sh_q  <= data;
			crc_q <= CRC_INIT;
		end else if (busy_q) begin
			sh_q  <= sh_q >> 1;
			crc_q <= (crc_q >> 1) ^ (fb ? CRC_POLY : 16'd0);
		end
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import ssd_pkg::*;

	localparam int GUARD_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_word_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	ssd_in_if  in_ch ();
	ssd_out_if out_ch ();

	skid_steer_drive_bridge u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	cfg_t        cfg;
	logic        drive_on = 1'b0;
	logic [6:0]  left_power = '0;
	logic [6:0]  right_power = '0;
	logic [7:0]  flags = '0;
	logic [15:0] silence = '0;
	frame_word_t frame_q[$];

	int fail_cnt     = 0;
	int idle_pct     = 0;
	int stall_pct    = 0;
	int quiet_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk)
		out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

	function automatic logic [6:0] side_power(longint v);
		longint mag;
		longint den;
		longint p;
		mag = (v < 0) ? -v : v;
		den = longint'(cfg.max_speed == 16'd0 ? 16'd1 : cfg.max_speed) * 1000;
		p = mag * 100 / den;
		return (p > 100) ? PCT_MAX : p[6:0];
	endfunction

	function automatic logic [15:0] modbus_crc(logic [31:0] head);
		logic [15:0] crc;
		crc = CRC_INIT;
		for (int i = 3; i >= 0; i--) begin
			crc ^= {8'h00, head[i*8 +: 8]};
			for (int k = 0; k < 8; k++)
				crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
		end
		return crc;
	endfunction

	function automatic void halt_drive();
		left_power = '0;
		right_power = '0;
		flags = FLAGS_BRAKE;
		drive_on = 1'b0;
	endfunction

	function automatic void advance_bridge(logic [1:0] op, logic signed [15:0] lin,
			logic signed [15:0] ang, logic en);
		longint      turn;
		longint      vl;
		longint      vr;
		logic [15:0] crc;
		logic [7:0]  fr [FRAME_BYTES];
		frame_word_t w;
		case (op)
		OP_COMMAND: begin
			silence = '0;
			if (drive_on) begin
				turn = longint'(ang) * longint'(cfg.half_base);
				vl = longint'(lin) * 1000 - turn;
				vr = longint'(lin) * 1000 + turn;
				flags = FLAG_IGNITION;
				if (vl < 0)
					flags |= FLAG_LEFT_REV;
				if (vr < 0)
					flags |= FLAG_RIGHT_REV;
				left_power = side_power(vl);
				right_power = side_power(vr);
			end
		end
		OP_MODE: begin
			if (en && !drive_on)
				drive_on = 1'b1;
			else if (!en && drive_on)
				halt_drive();
		end
		OP_TICK: begin
			if (silence != 16'hFFFF)
				silence++;
			if (silence > cfg.watchdog && drive_on)
				halt_drive();
		end
		default: begin
			crc = modbus_crc({FRAME_SOF, 1'b0, left_power, 1'b0, right_power, flags});
			fr = '{FRAME_SOF, {1'b0, left_power}, {1'b0, right_power}, flags,
				crc[15:8], crc[7:0], FRAME_CR, FRAME_LF};
			foreach (fr[k]) begin
				w.data = fr[k];
				w.last = (k == FRAME_BYTES - 1);
				frame_q.insert(frame_q.size(), w);
			end
		end
		endcase
	endfunction

	always @(posedge clk) begin : word_check
		frame_word_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (frame_q.size() == 0) begin
				$error("unexpected word: tx_byte %h last_byte %b", out_ch.tx_byte,
					out_ch.last_byte);
				fail_cnt++;
			end else begin
				want = frame_q.pop_front();
				if (out_ch.tx_byte !== want.data) begin
					$error("tx_byte: expected %h, got %h", want.data, out_ch.tx_byte);
					fail_cnt++;
				end
				if (out_ch.last_byte !== want.last) begin
					$error("last_byte: expected %b, got %b", want.last, out_ch.last_byte);
					fail_cnt++;
				end
			end
		end
		if (arst_n && in_ch.valid && in_ch.ready)
			advance_bridge(in_ch.operation, in_ch.linear_mm_s, in_ch.angular_mrad_s,
				in_ch.drive_req);
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= GUARD_LIMIT) begin
			$display("skid_steer_drive_bridge verification failed");
			$finish;
		end
	end

	task automatic push_word(logic [1:0] op, logic [15:0] lin, logic [15:0] ang, logic en);
		int gap = 0;
		while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.linear_mm_s <= lin;
		in_ch.angular_mrad_s <= ang;
		in_ch.drive_req <= en;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// drop valid, wait for the frame queue to drain and the last command to finish
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (frame_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'h0000, val};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
		REG_HALF_BASE: cfg.half_base = val;
		REG_MAX_SPEED: cfg.max_speed = val;
		default: cfg.watchdog = val;
		endcase
	endtask

	task automatic check_reg(logic [1:0] idx);
		logic [15:0] want;
		case (idx)
		REG_HALF_BASE: want = cfg.half_base;
		REG_MAX_SPEED: want = cfg.max_speed;
		default: want = cfg.watchdog;
		endcase
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== {16'h0000, want}) begin
			$error("prdata: expected %h, got %h", {16'h0000, want}, prdata);
			fail_cnt++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_registers();
		check_reg(REG_HALF_BASE);
		check_reg(REG_MAX_SPEED);
		check_reg(REG_WATCHDOG);
		cfg_write(REG_HALF_BASE, 16'hFFFF);
		cfg_write(REG_MAX_SPEED, 16'd1);
		cfg_write(REG_WATCHDOG, 16'hFFFF);
		check_reg(REG_HALF_BASE);
		check_reg(REG_MAX_SPEED);
		check_reg(REG_WATCHDOG);
		cfg_write(REG_HALF_BASE, 16'd0);
		cfg_write(REG_MAX_SPEED, 16'hFFFF);
		cfg_write(REG_WATCHDOG, 16'd1);
		check_reg(REG_HALF_BASE);
		check_reg(REG_MAX_SPEED);
		check_reg(REG_WATCHDOG);
	endtask

	task automatic test_pause();
		push_word(OP_SEND, 16'h0000, 16'h0000, 1'b0);
		push_word(OP_COMMAND, 16'h7FFF, 16'h8000, 1'b1);
		push_word(OP_MODE, 16'hFFFF, 16'hFFFF, 1'b0);
		push_word(OP_SEND, 16'hFFFF, 16'h0000, 1'b1);
	endtask

	task automatic test_mixing();
		settle();
		cfg_write(REG_HALF_BASE, HALF_BASE_RST);
		cfg_write(REG_MAX_SPEED, MAX_SPEED_RST);
		cfg_write(REG_WATCHDOG, WATCHDOG_RST);
		push_word(OP_MODE, 16'h0000, 16'h0000, 1'b1);
		push_word(OP_COMMAND, 16'd1000, 16'd0, 1'b0);
		push_word(OP_SEND, 16'h0000, 16'h0000, 1'b0);
		push_word(OP_COMMAND, 16'h8000, 16'h7FFF, 1'b0);
		push_word(OP_SEND, 16'h0000, 16'h0000, 1'b0);
		push_word(OP_COMMAND, 16'h7FFF, 16'h8000, 1'b1);
		push_word(OP_SEND, 16'h0000, 16'h0000, 1'b0);
		// tiny negative left side: reverse set, zero power
		push_word(OP_COMMAND, 16'd0, 16'd1, 1'b0);
		push_word(OP_SEND, 16'h0000, 16'h0000, 1'b0);
		push_word(OP_MODE, 16'h0000, 16'h0000, 1'b1);
		push_word(OP_MODE, 16'h0000, 16'h0000, 1'b0);
		push_word(OP_SEND, 16'h0000, 16'h0000, 1'b0);
	endtask

	task automatic test_watchdog();
		settle();
		cfg_write(REG_WATCHDOG, 16'd2);
		push_word(OP_MODE, 16'h0000, 16'h0000, 1'b1);
		push_word(OP_COMMAND, 16'd500, -16'sd200, 1'b0);
		push_word(OP_TICK, 16'h0000, 16'h0000, 1'b0);
		push_word(OP_TICK, 16'h0000, 16'h0000, 1'b0);
		push_word(OP_SEND, 16'h0000, 16'h0000, 1'b0);
		push_word(OP_TICK, 16'h0000, 16'h0000, 1'b0);
		push_word(OP_SEND, 16'h0000, 16'h0000, 1'b0);
	endtask

	task automatic test_zero_max();
		settle();
		cfg_write(REG_MAX_SPEED, 16'd0);
		cfg_write(REG_WATCHDOG, WATCHDOG_RST);
		push_word(OP_MODE, 16'h0000, 16'h0000, 1'b1);
		push_word(OP_COMMAND, 16'd1, 16'd0, 1'b0);
		push_word(OP_SEND, 16'h0000, 16'h0000, 1'b0);
	endtask

	// hold drive while the silence count equals the limit, brake one tick later
	task automatic test_silence_limit();
		settle();
		cfg_write(REG_MAX_SPEED, MAX_SPEED_RST);
		cfg_write(REG_WATCHDOG, 16'd5);
		push_word(OP_MODE, 16'h0000, 16'h0000, 1'b1);
		push_word(OP_COMMAND, 16'd300, 16'd100, 1'b0);
		repeat (5) push_word(OP_TICK, 16'h0000, 16'h0000, 1'b0);
		push_word(OP_SEND, 16'h0000, 16'h0000, 1'b0);
		push_word(OP_TICK, 16'h0000, 16'h0000, 1'b0);
		push_word(OP_SEND, 16'h0000, 16'h0000, 1'b0);
	endtask

	task automatic test_random(int count, int idle, int stall, logic [15:0] half,
			logic [15:0] maxs, logic [15:0] wd);
		int          pick;
		int          burst;
		logic [15:0] lin;
		logic [15:0] ang;
		settle();
		cfg_write(REG_HALF_BASE, half);
		cfg_write(REG_MAX_SPEED, maxs);
		cfg_write(REG_WATCHDOG, wd);
		idle_pct = idle;
		stall_pct = stall;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			lin = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 6000) - 3000);
			ang = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 6000) - 3000);
			if (pick < 35) begin
				push_word(OP_COMMAND, lin, ang, 1'($urandom));
			end else if (pick < 50) begin
				push_word(OP_MODE, lin, ang, $urandom_range(0, 99) < 80);
			end else if (pick < 75) begin
				burst = ($urandom_range(0, 19) == 0 && cfg.watchdog < 400) ?
					int'(cfg.watchdog) + 2 : $urandom_range(1, 4);
				repeat (burst) push_word(OP_TICK, 16'($urandom), 16'($urandom), 1'($urandom));
			end else begin
				push_word(OP_SEND, lin, ang, 1'($urandom));
			end
		end
		settle();
		idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.operation = OP_COMMAND;
		in_ch.linear_mm_s = '0;
		in_ch.angular_mrad_s = '0;
		in_ch.drive_req = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg = '{HALF_BASE_RST, MAX_SPEED_RST, WATCHDOG_RST};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_registers();
		test_pause();
		test_mixing();
		test_watchdog();
		test_zero_max();
		test_silence_limit();
		test_random(65, 0, 0, 16'd350, 16'd2780, 16'd12);
		test_random(65, 67, 0, 16'hFFFF, 16'd1, 16'd1);
		test_random(65, 0, 67, 16'd0, 16'hFFFF, 16'hFFFF);
		test_random(65, 31, 31, 16'($urandom_range(0, 2000)), 16'($urandom_range(0, 5000)),
			16'($urandom_range(2, 30)));

		if (fail_cnt == 0 && frame_q.size() == 0)
			$display("skid_steer_drive_bridge verification clean");
		else
			$display("skid_steer_drive_bridge verification failed");
		$finish;
	end

endmodule
